// ===== sv/mprm_pkg.sv =====
// Shared types, constants and helpers for the multi-pattern response matcher.
// No dependencies; every other file except the checker imports this package.
package mprm_pkg;

  localparam int NUM_PATTERNS  = 4;
  localparam int PATTERN_CHARS = 8;
  localparam int BUFFER_DEPTH  = 64;

  // Widths fixed by the register and field layout
  localparam int SLOTS      = 4;
  localparam int SLOT_W     = 2;
  localparam int LEN_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int CHAR_SEL_W = 3;
  localparam int PATTERN_W  = 64;
  localparam int START_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int TIMER_W    = 24;
  localparam int TICK_W     = 8;
  localparam int OP_W       = 2;
  localparam int REG_IDX_W  = 3;
  localparam int LENGTHS_W  = SLOTS * LEN_W;

  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_0   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_1   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_2   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_3   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LENGTHS     = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_ARM     = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  // Item as it travels down the row of cells
  typedef struct packed {
    logic                             rx;
    logic                             clr;
    logic [CHAR_W-1:0]                folded;
    logic [FILL_W-1:0]                fill;
    logic [TIMER_W-1:0]               timer;
    logic [SLOTS-1:0]                 mask;
    logic [SLOTS-1:0][START_W-1:0]    start;
  } tok_t;

  // Result item as presented on the output ports
  typedef struct packed {
    logic [SLOTS-1:0]                 mask;
    logic [SLOTS-1:0][START_W-1:0]    start;
    logic [COUNT_W-1:0]               fill;
    logic [TIMER_W-1:0]               timer;
    logic                             timed_out;
  } res_t;

  // Fold lower-case letters to upper case
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] r;
    r = ch;
    if (ch inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
      r = ch & ~CASE_BIT;
    end
    return r;
  endfunction

endpackage

// ===== sv/mprm_head.sv =====
// Head stage: fill level, clear decision, case folding and answer timer.
// Depends on mprm_pkg.
module mprm_head (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [1:0]             operation,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             tick_ms,
  input  logic [23:0]            timeout_ms,
  output logic                   tok_valid,
  output mprm_pkg::tok_t         tok
);
  import mprm_pkg::*;

  logic [FILL_W-1:0]  fill, fill_next;
  logic [TIMER_W-1:0] timer, timer_next;
  logic               clr, rx;

  always_comb begin
    fill_next  = fill;
    timer_next = timer;
    clr        = 1'b0;
    rx         = 1'b0;
    case (op_t'(operation))
      OP_RECEIVE: begin
        rx = 1'b1;
        if (fill >= FILL_W'(BUFFER_DEPTH)) begin
          clr       = 1'b1;
          fill_next = FILL_W'(1);
        end else begin
          fill_next = fill + FILL_W'(1);
        end
      end
      OP_FLUSH: begin
        clr       = 1'b1;
        fill_next = '0;
      end
      OP_ARM: begin
        timer_next = timeout_ms;
      end
      OP_TICK: begin
        if (timer > TIMER_W'(tick_ms)) begin
          timer_next = timer - TIMER_W'(tick_ms);
        end else begin
          timer_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      timer     <= '0;
      tok_valid <= 1'b0;
    end else if (adv) begin
      tok_valid <= in_valid;
      if (in_valid) begin
        fill  <= fill_next;
        timer <= timer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      tok.rx     <= rx;
      tok.clr    <= clr;
      tok.folded <= fold_case(rx_byte);
      tok.fill   <= fill_next;
      tok.timer  <= timer_next;
      tok.mask   <= '0;
      tok.start  <= '0;
    end
  end

endmodule

// ===== sv/mprm_cell.sv =====
// One matcher cell: owns one pattern slot's progress, found flag and start.
// Depends on mprm_pkg.
module mprm_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [mprm_pkg::SLOT_W-1:0]  slot,
  input  logic [63:0]                  pattern,
  input  logic [mprm_pkg::LEN_W-1:0]   len_raw,
  input  logic                         tok_in_valid,
  input  mprm_pkg::tok_t               tok_in,
  output logic                         tok_out_valid,
  output mprm_pkg::tok_t               tok_out
);
  import mprm_pkg::*;

  logic [LEN_W-1:0]   prog, prog_next, prog_base, prog_inc;
  logic               found, found_next, found_base;
  logic [START_W-1:0] start, start_next, start_base;
  logic [LEN_W-1:0]   len;
  logic [CHAR_W-1:0]  want;
  tok_t               tok_next;

  assign len = (len_raw > LEN_W'(PATTERN_CHARS)) ? LEN_W'(PATTERN_CHARS) : len_raw;

  always_comb begin
    prog_base  = tok_in.clr ? '0 : prog;
    found_base = tok_in.clr ? 1'b0 : found;
    start_base = tok_in.clr ? '0 : start;
    prog_inc   = prog_base + LEN_W'(1);
    want       = fold_case(pattern[{prog_base[CHAR_SEL_W-1:0], 3'b000} +: CHAR_W]);
    prog_next  = prog_base;
    found_next = found_base;
    start_next = start_base;
    if (tok_in.rx && (len != '0) && !found_base) begin
      // Naive rule: a mismatch drops progress without rechecking the byte
      if (prog_base >= len) begin
        prog_next = '0;
      end else if (want == tok_in.folded) begin
        prog_next = prog_inc;
        if (prog_inc == len) begin
          found_next = 1'b1;
          start_next = START_W'(tok_in.fill) - START_W'(prog_inc);
        end
      end else begin
        prog_next = '0;
      end
    end
  end

  // Pass the item on with this slot's flag and start filled in
  always_comb begin
    tok_next             = tok_in;
    tok_next.mask[slot]  = found_next;
    tok_next.start[slot] = start_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog          <= '0;
      found         <= 1'b0;
      start         <= '0;
      tok_out_valid <= 1'b0;
    end else if (adv) begin
      tok_out_valid <= tok_in_valid;
      if (tok_in_valid) begin
        prog  <= prog_next;
        found <= found_next;
        start <= start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_in_valid) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== sv/mprm_out.sv =====
// Output register with a one-entry skid stage behind it.
// Depends on mprm_pkg.
module mprm_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mprm_pkg::tok_t  tok,
  input  logic            out_stall,
  output logic            out_valid,
  output mprm_pkg::res_t  res,
  output logic            skid_valid
);
  import mprm_pkg::*;

  res_t new_res, skid;
  logic take;

  assign take = out_valid && !out_stall;

  always_comb begin
    new_res.mask      = tok.mask;
    new_res.start     = tok.start;
    new_res.fill      = COUNT_W'(tok.fill);
    new_res.timer     = tok.timer;
    new_res.timed_out = (tok.timer == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        res <= skid;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid <= new_res;
      end else begin
        res <= new_res;
      end
    end
  end

endmodule

// ===== sv/multi_pattern_response_matcher.sv =====
// A result passes through the head, one stage per cell and the output register.
// Throughput: one item per cycle while in_stall is low; every stage of the cell row advances together.
// in_stall rises only while the skid stage holds a result behind a stalled output.
// Reset (rst, synchronous): clears pattern registers, fill level, progress, flags, starts,
// timer and all valid flags.
module multi_pattern_response_matcher (
  input  logic          clk,
  input  logic          rst,
  // configuration write port
  input  logic          write_enable,
  input  logic [2:0]    write_index,
  input  logic [63:0]   write_data,
  // input channel
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    operation,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    tick_ms,
  input  logic [23:0]   timeout_ms,
  // output channel
  output logic          out_valid,
  input  logic          out_stall,
  output logic [3:0]    matched_mask,
  output logic [5:0]    start_0,
  output logic [5:0]    start_1,
  output logic [5:0]    start_2,
  output logic [5:0]    start_3,
  output logic [6:0]    fill_count,
  output logic [23:0]   timer_left,
  output logic          timed_out
);
  import mprm_pkg::*;

  // Pattern registers; slot i characters, first in the low byte
  logic [SLOTS-1:0][PATTERN_W-1:0] patterns;
  logic [LENGTHS_W-1:0]            lengths;

  // The whole row moves in lockstep unless the skid stage is occupied
  logic adv;
  logic skid_valid;

  tok_t chain_tok   [NUM_PATTERNS+1];
  logic [NUM_PATTERNS:0] chain_valid;

  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      patterns <= '0;
      lengths  <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_PATTERN_0: patterns[0] <= write_data;
        REG_PATTERN_1: patterns[1] <= write_data;
        REG_PATTERN_2: patterns[2] <= write_data;
        REG_PATTERN_3: patterns[3] <= write_data;
        REG_LENGTHS:   lengths     <= write_data[LENGTHS_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  // Head: bookkeeping that is shared by all slots (fill, clear, timer)
  mprm_head u_head (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .operation  (operation),
    .rx_byte    (rx_byte),
    .tick_ms    (tick_ms),
    .timeout_ms (timeout_ms),
    .tok_valid  (chain_valid[0]),
    .tok        (chain_tok[0])
  );

  // Row of cells: cell i updates slot i as the item passes and writes its
  // flag and start into the item. Slots beyond NUM_PATTERNS stay clear.
  for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
    mprm_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .adv           (adv),
      .slot          (SLOT_W'(i)),
      .pattern       (patterns[i]),
      .len_raw       (lengths[LEN_W*i +: LEN_W]),
      .tok_in_valid  (chain_valid[i]),
      .tok_in        (chain_tok[i]),
      .tok_out_valid (chain_valid[i+1]),
      .tok_out       (chain_tok[i+1])
    );
  end

  // Output register and skid stage: the tail transfer lands in the skid
  // when the output is held, which then freezes the row next cycle.
  mprm_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (adv && chain_valid[NUM_PATTERNS]),
    .tok        (chain_tok[NUM_PATTERNS]),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .res        (res),
    .skid_valid (skid_valid)
  );

  assign matched_mask = res.mask;
  assign start_0      = res.start[0];
  assign start_1      = res.start[1];
  assign start_2      = res.start[2];
  assign start_3      = res.start[3];
  assign fill_count   = res.fill;
  assign timer_left   = res.timer;
  assign timed_out    = res.timed_out;

endmodule

// ===== sv/mprm_checker.sv =====
// Port-level checks on the matcher's result channel, bound to the top level.
// Depends on multi_pattern_response_matcher.
module mprm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  matched_mask,
  input logic [5:0]  start_0,
  input logic [5:0]  start_1,
  input logic [5:0]  start_2,
  input logic [5:0]  start_3,
  input logic [23:0] timer_left,
  input logic        timed_out
);

  // A held result stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_timed_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (timed_out == (timer_left == 24'd0)))
    else $error("timed_out disagrees with timer_left");

  a_start_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((matched_mask[0] || start_0 == 6'd0) &&
                   (matched_mask[1] || start_1 == 6'd0)))
    else $error("start reported for an unmatched slot (0/1)");

  a_start_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((matched_mask[2] || start_2 == 6'd0) &&
                   (matched_mask[3] || start_3 == 6'd0)))
    else $error("start reported for an unmatched slot (2/3)");

endmodule

bind multi_pattern_response_matcher mprm_checker u_mprm_checker (.*);

// ===== bench/tb_multi_pattern_response_matcher.sv =====
// Self-checking bench for multi_pattern_response_matcher: a directed table, then random phases.
// Predicts results from a copy of pattern registers, matcher state and timer, or a typed one.
// Depends on mprm_pkg (sv/mprm_pkg.sv) and the RTL of the block; reads no files.
module tb_multi_pattern_response_matcher;
  import mprm_pkg::*;

  localparam int LATENCY        = 5;     // extra drain wait once no status is pending
  localparam int MAX_WAIT       = 12;    // longest gap or stall drawn per item
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 150;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  // One line of the directed plan: a register write or an input item,
  // optionally with a result typed in by hand
  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        reg_idx;
    op_t               op;
    logic [63:0]       arg;
    logic              has_known;
    res_t              known;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic write_enable;
  logic [2:0] write_index;
  logic [63:0] write_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [7:0] tick_ms;
  logic [23:0] timeout_ms;
  logic out_valid;
  logic out_stall;
  logic [3:0] matched_mask;
  logic [5:0] start_0;
  logic [5:0] start_1;
  logic [5:0] start_2;
  logic [5:0] start_3;
  logic [6:0] fill_count;
  logic [23:0] timer_left;
  logic timed_out;

  // Predictor copy of the configuration and the matcher state
  logic [63:0] pat_reg [SLOTS];
  logic [15:0] len_reg;
  logic [6:0] fill_lvl;
  logic [3:0] prog [SLOTS];
  logic [3:0] found;
  logic [6:0] found_pos [SLOTS];
  logic [23:0] tmr;

  res_t pending_status [$];   // predicted status words, oldest first
  plan_row_t plan [$];
  int mismatches = 0;
  int items_issued = 0;
  bit quiet_phase = 1'b0;     // when set, neither side idles

  multi_pattern_response_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .rx_byte      (rx_byte),
    .tick_ms      (tick_ms),
    .timeout_ms   (timeout_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matched_mask (matched_mask),
    .start_0      (start_0),
    .start_1      (start_1),
    .start_2      (start_2),
    .start_3      (start_3),
    .fill_count   (fill_count),
    .timer_left   (timer_left),
    .timed_out    (timed_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fold a..z to upper case; every other byte passes through
  function automatic logic [7:0] upcase(logic [7:0] c);
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      return c & ~CASE_BIT;
    end
    return c;
  endfunction

  // Effective length of a slot: lengths above PATTERN_CHARS clamp to it
  function automatic logic [3:0] slot_len(int s);
    logic [3:0] l;
    l = len_reg[4*s +: 4];
    if (l > PATTERN_CHARS) begin
      l = 4'(PATTERN_CHARS);
    end
    return l;
  endfunction

  // Drop the buffer contents and every match; the timer is untouched
  function automatic void clear_matches();
    fill_lvl = '0;
    found = '0;
    for (int s = 0; s < SLOTS; s++) begin
      prog[s] = '0;
      found_pos[s] = '0;
    end
  endfunction

  // Apply one input item to the state copy and return the status that follows it
  function automatic res_t advance_matcher(op_t op, logic [7:0] rx, logic [7:0] tick,
                                           logic [23:0] load);
    res_t r;
    logic [7:0] folded;
    logic [7:0] want;
    logic [3:0] len;
    folded = upcase(rx);
    case (op)
      OP_RECEIVE: begin
        // A full buffer starts over, and this byte becomes the first one
        if (fill_lvl >= BUFFER_DEPTH) begin
          clear_matches();
        end
        fill_lvl = fill_lvl + 1'b1;
        for (int s = 0; s < NUM_PATTERNS; s++) begin
          len = slot_len(s);
          // Unused slots never match; latched slots freeze progress and start
          if (len != 0 && !found[s]) begin
            if (prog[s] >= len) begin
              // Progress left over from a longer length: count as a mismatch
              prog[s] = '0;
            end else begin
              want = upcase(pat_reg[s][8*prog[s] +: 8]);
              if (want == folded) begin
                prog[s] = prog[s] + 1'b1;
                if (prog[s] == len) begin
                  found[s] = 1'b1;
                  found_pos[s] = fill_lvl - prog[s];
                end
              end else begin
                // Naive rule: restart without retrying this byte as a first character
                prog[s] = '0;
              end
            end
          end
        end
      end
      OP_FLUSH: begin
        clear_matches();
      end
      OP_ARM: begin
        tmr = load;
      end
      OP_TICK: begin
        // Count down and saturate at zero
        if (tmr > tick) begin
          tmr = tmr - tick;
        end else begin
          tmr = '0;
        end
      end
      default: ;
    endcase
    r.mask = found;
    for (int s = 0; s < SLOTS; s++) begin
      r.start[s] = found[s] ? found_pos[s][5:0] : '0;
    end
    r.fill = fill_lvl;
    r.timer = tmr;
    r.timed_out = (tmr == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_write(logic [2:0] idx, logic [63:0] value);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.arg = value;
    plan.push_back(row);
  endfunction

  function automatic void add_item(op_t op, logic [23:0] arg);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.arg = {40'h0, arg};
    plan.push_back(row);
  endfunction

  // Item whose status is obvious: no match latched, so only fill and timer matter
  function automatic void add_known(op_t op, logic [23:0] arg, logic [6:0] fill,
                                    logic [23:0] timer, logic expired);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.arg = {40'h0, arg};
    row.has_known = 1'b1;
    row.known.fill = fill;
    row.known.timer = timer;
    row.known.timed_out = expired;
    plan.push_back(row);
  endfunction

  // Pattern characters: letters of both cases, digits, the bytes right next to
  // the letter ranges (not folded), NUL, 0xFF and anything else
  function automatic logic [7:0] pattern_char();
    logic [7:0] edges [4];
    edges = '{8'h40, 8'h5B, 8'h60, 8'h7B};
    case ($urandom_range(0, 7))
      0, 1: return 8'h41 + 8'($urandom_range(0, 25));
      2:    return CHAR_LOW_A + 8'($urandom_range(0, 25));
      3:    return 8'h30 + 8'($urandom_range(0, 9));
      4:    return edges[$urandom_range(0, 3)];
      5:    return 8'h00;
      6:    return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    return $urandom_range(0, 1) ? pattern_char() : 8'($urandom_range(0, 255));
  endfunction

  // Present one item, hold it until the transfer, then record its prediction.
  // Fields that the operation ignores carry random values.
  task automatic issue(op_t op, logic [23:0] arg, logic has_known, res_t known);
    int gap;
    logic [7:0] rb;
    logic [7:0] tk;
    logic [23:0] to;
    res_t predicted;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
    rb = 8'($urandom);
    tk = 8'($urandom);
    to = 24'($urandom);
    case (op)
      OP_RECEIVE: rb = arg[7:0];
      OP_TICK:    tk = arg[7:0];
      OP_ARM:     to = arg;
      default: ;
    endcase
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    rx_byte = rb;
    tick_ms = tk;
    timeout_ms = to;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    predicted = advance_matcher(op, rb, tk, to);
    pending_status.push_back(has_known ? known : predicted);
    items_issued++;
  endtask

  // Drop valid, wait for every pending status, then let the pipeline run dry
  task automatic settle_pipeline();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  // Registers change only with the block idle
  task automatic write_register(logic [2:0] idx, logic [63:0] value);
    settle_pipeline();
    @(negedge clk);
    write_enable = 1'b1;
    write_index = idx;
    write_data = value;
    @(negedge clk);
    write_enable = 1'b0;
    if (idx == REG_LENGTHS) begin
      len_reg = value[15:0];
    end else begin
      pat_reg[idx] = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per result, compare against the oldest prediction
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endfunction

  initial begin
    int hold;
    res_t want;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) begin
        @(posedge clk);
      end
      if (pending_status.size() == 0) begin
        mismatches++;
        $error("status transfer with no prediction pending");
      end else begin
        want = pending_status.pop_front();
        check_field("matched_mask", 24'(want.mask), 24'(matched_mask));
        check_field("start_0", 24'(want.start[0]), 24'(start_0));
        check_field("start_1", 24'(want.start[1]), 24'(start_1));
        check_field("start_2", 24'(want.start[2]), 24'(start_2));
        check_field("start_3", 24'(want.start[3]), 24'(start_3));
        check_field("fill_count", 24'(want.fill), 24'(fill_count));
        check_field("timer_left", want.timer, timer_left);
        check_field("timed_out", 24'(want.timed_out), 24'(timed_out));
      end
    end
  end

  // Watchdog: any transfer or register write restarts the count
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          write_enable || rst) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    int s;
    int k;
    int cut;
    int lead;
    int roll;
    int phase_end;
    bit no_flush;
    logic [7:0] c;
    logic [63:0] p;
    logic [15:0] lens;
    logic [23:0] load_val;

    // Drive every input to a known value before the first edge
    rst = 1'b1;
    write_enable = 1'b0;
    write_index = REG_PATTERN_0;
    write_data = '0;
    in_valid = 1'b0;
    operation = OP_RECEIVE;
    rx_byte = '0;
    tick_ms = '0;
    timeout_ms = '0;
    for (s = 0; s < SLOTS; s++) begin
      pat_reg[s] = '0;
    end
    len_reg = '0;
    clear_matches();
    tmr = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed plan
    add_write(REG_PATTERN_0, 64'h4B4F);              // "OK"
    add_write(REG_PATTERN_1, 64'h72_6F72_7265);      // "error", lower case in the register
    add_write(REG_PATTERN_2, 64'h42_0041);           // "A", NUL, "B": NUL is a real character
    add_write(REG_PATTERN_3, '1);                    // eight 0xFF bytes
    add_write(REG_LENGTHS, 16'hF352);                // slot 3 length 15 clamps to 8
    add_known(OP_TICK, 24'd0, 7'd0, 24'h0, 1'b1);    // tick on a timer already at zero
    add_known(OP_ARM, 24'hFFFFFF, 7'd0, 24'hFFFFFF, 1'b0);
    add_known(OP_TICK, 24'd255, 7'd0, 24'hFFFF00, 1'b0);
    add_known(OP_ARM, 24'd5, 7'd0, 24'd5, 1'b0);
    add_known(OP_TICK, 24'd200, 7'd0, 24'h0, 1'b1);  // tick past the remaining time
    add_known(OP_ARM, 24'd0, 7'd0, 24'h0, 1'b1);
    add_item(OP_RECEIVE, "o");                       // case folding on the received side
    add_item(OP_RECEIVE, "k");
    add_item(OP_RECEIVE, "E");
    add_item(OP_RECEIVE, "R");
    add_item(OP_RECEIVE, "X");                       // mismatch drops progress to zero
    add_item(OP_RECEIVE, "E");
    add_item(OP_RECEIVE, "R");
    add_item(OP_RECEIVE, "r");
    add_item(OP_RECEIVE, "O");
    add_item(OP_RECEIVE, "r");
    add_item(OP_RECEIVE, "A");
    add_item(OP_RECEIVE, 24'h00);
    add_item(OP_RECEIVE, "b");
    add_item(OP_RECEIVE, 24'hFF);
    add_known(OP_FLUSH, 24'd0, 7'd0, 24'h0, 1'b1);   // flush keeps the timer
    add_item(OP_RECEIVE, "e");
    add_item(OP_RECEIVE, "R");
    add_write(REG_LENGTHS, 16'hF312);                // shrink slot 1 below its progress
    add_item(OP_RECEIVE, "E");                       // stale progress: counts as a mismatch
    add_item(OP_RECEIVE, "e");

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_register(plan[i].reg_idx, plan[i].arg);
      end else begin
        issue(plan[i].op, plan[i].arg[23:0], plan[i].has_known, plan[i].known);
      end
    end

    // Random phases, each with fresh register settings. Match state is not
    // flushed between phases, so stale progress carries over on purpose.
    for (ph = 0; ph < PHASES; ph++) begin
      for (s = 0; s < SLOTS; s++) begin
        case (ph)
          0:       p = '1;
          1, 2:    p = '0;
          default: begin
            for (k = 0; k < PATTERN_CHARS; k++) begin
              p[8*k +: 8] = pattern_char();
            end
          end
        endcase
        write_register(3'(REG_PATTERN_0 + s), p);
      end
      case (ph)
        0:       lens = '1;         // every slot clamps to eight 0xFF bytes
        1:       lens = '0;         // all slots unused
        2:       lens = 16'h8888;   // eight NUL characters per slot
        default: begin
          for (s = 0; s < SLOTS; s++) begin
            case ($urandom_range(0, 5))
              0:       lens[4*s +: 4] = 4'd0;
              1:       lens[4*s +: 4] = 4'($urandom_range(9, 15));
              5:       lens[4*s +: 4] = 4'($urandom_range(1, 3));
              default: lens[4*s +: 4] = 4'($urandom_range(1, 8));
            endcase
          end
        end
      endcase
      write_register(REG_LENGTHS, {48'h0, lens});

      // Some phases run without idling; some never flush, so the buffer overflows
      quiet_phase = (ph % 4 == 3);
      no_flush = (ph % 3 == 1);
      phase_end = items_issued + PHASE_ITEMS;
      while (items_issued < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          // Send a slot's pattern with random case, a little noise ahead,
          // and now and then one character corrupted
          s = $urandom_range(0, SLOTS - 1);
          lead = $urandom_range(0, 2);
          cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PATTERN_CHARS - 1)
                                             : PATTERN_CHARS;
          repeat (lead) issue(OP_RECEIVE, {16'h0, noise_byte()}, 1'b0, '0);
          for (k = 0; k < slot_len(s); k++) begin
            c = pat_reg[s][8*k +: 8];
            if (k == cut) begin
              c = noise_byte();
            end else if ((c | CASE_BIT) >= CHAR_LOW_A && (c | CASE_BIT) <= CHAR_LOW_Z &&
                         $urandom_range(0, 1)) begin
              c = c ^ CASE_BIT;
            end
            issue(OP_RECEIVE, {16'h0, c}, 1'b0, '0);
          end
        end else if (roll < 75 || (roll < 80 && no_flush)) begin
          issue(OP_RECEIVE, {16'h0, noise_byte()}, 1'b0, '0);
        end else if (roll < 80) begin
          issue(OP_FLUSH, 24'($urandom), 1'b0, '0);
        end else if (roll < 88) begin
          case ($urandom_range(0, 3))
            0:       load_val = '0;
            1:       load_val = '1;
            2:       load_val = 24'($urandom_range(1, 600));
            default: load_val = 24'($urandom);
          endcase
          issue(OP_ARM, load_val, 1'b0, '0);
        end else begin
          issue(OP_TICK, 24'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end

    // Drain and give any stray status time to show up
    settle_pipeline();
    repeat (4 * LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
